// ----- hw/rtl/sftb_pkg.sv -----
// ---------------------------------------------------------------------------
// sftb_pkg
// Shared types and constants for the scrolling flame texture blend core.
// ---------------------------------------------------------------------------
package sftb_pkg;

    localparam int TEX_WIDTH     = 32;
    localparam int TEX_HEIGHT    = 64;
    localparam int SCALED_HEIGHT = 128;

    localparam int COL_W   = $clog2(TEX_WIDTH);
    localparam int LROW_W  = $clog2(TEX_HEIGHT);
    localparam int UROW_W  = $clog2(SCALED_HEIGHT);
    localparam int ROW_W   = 7;
    localparam int PIX_W   = 8;
    localparam int MASK_AW = LROW_W + COL_W;
    localparam int SCAL_AW = UROW_W + COL_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_SPEED = 1'b1;

    localparam logic [LROW_W-1:0] LOWER_SPEED_RESET  = LROW_W'(2);
    localparam logic [UROW_W-1:0] UPPER_SPEED_RESET  = UROW_W'(4);
    localparam logic [UROW_W-1:0] UPPER_OFFSET_RESET = UROW_W'(48 % SCALED_HEIGHT);

    localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;
    localparam logic [2*PIX_W-1:0] SCREEN_BIAS = 16'd65280;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD_MASK   = 2'd0,
        OP_LOAD_SCALED = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_ADVANCE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        K_LOAD_MASK   = 2'd0,
        K_LOAD_SCALED = 2'd1,
        K_COMPUTE     = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [MASK_AW-1:0]  mask_addr;
        logic [SCAL_AW-1:0]  scaled_addr;
        logic [PIX_W-1:0]    value;
        logic [LROW_W-1:0]   row;
        logic [COL_W-1:0]    col;
    } cmd_t;

    // screen(a, b) = (65280 - (255 - a) * (255 - b)) >> 8
    function automatic logic [PIX_W-1:0] screen_blend(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b);
        logic [2*PIX_W-1:0] inv_a;
        logic [2*PIX_W-1:0] inv_b;
        logic [2*PIX_W-1:0] prod;
        logic [2*PIX_W-1:0] diff;
        inv_a = (2*PIX_W)'(PIX_MAX - a);
        inv_b = (2*PIX_W)'(PIX_MAX - b);
        prod  = inv_a * inv_b;
        diff  = SCREEN_BIAS - prod;
        return diff[2*PIX_W-1:PIX_W];
    endfunction

endpackage

// ----- hw/rtl/sftb_front.sv -----
// ---------------------------------------------------------------------------
// sftb_front
// Accepts input beats, holds scroll speeds and offsets, resolves mask
// addresses and forwards loads and computes to the command queue.
// ---------------------------------------------------------------------------
module sftb_front
    import sftb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [1:0]            opcode,
    input  logic [ROW_W-1:0]      row,
    input  logic [COL_W-1:0]      col,
    input  logic [PIX_W-1:0]      value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cmd_valid,
    output cmd_t                  cmd
);

    logic [LROW_W-1:0] lower_speed_reg, lower_speed_next;
    logic [UROW_W-1:0] upper_speed_reg, upper_speed_next;
    logic [LROW_W-1:0] lower_off_reg, lower_off_next;
    logic [UROW_W-1:0] upper_off_reg, upper_off_next;

    logic              accept;
    logic              col_ok;
    logic              row_ok_mask;
    logic              row_ok_scaled;
    logic [LROW_W:0]   lrow_sum;
    logic [UROW_W:0]   urow_sum;
    logic [LROW_W-1:0] lrow;
    logic [UROW_W-1:0] urow;
    logic [LROW_W:0]   ladv_sum;
    logic [UROW_W:0]   uadv_sum;

    assign accept        = push && !full;
    assign col_ok        = {1'b0, col} < (COL_W+1)'(TEX_WIDTH);
    assign row_ok_mask   = {1'b0, row} < (ROW_W+1)'(TEX_HEIGHT);
    assign row_ok_scaled = {1'b0, row} < (ROW_W+1)'(SCALED_HEIGHT);

    // sums stay below twice the height, so one subtract wraps them
    always_comb
    begin
        lrow_sum = {1'b0, row[LROW_W-1:0]} + {1'b0, lower_off_reg};
        if (lrow_sum >= (LROW_W+1)'(TEX_HEIGHT))
            lrow_sum = lrow_sum - (LROW_W+1)'(TEX_HEIGHT);
        lrow = lrow_sum[LROW_W-1:0];

        urow_sum = (UROW_W+1)'(row[LROW_W-1:0]) + {1'b0, upper_off_reg};
        if (urow_sum >= (UROW_W+1)'(SCALED_HEIGHT))
            urow_sum = urow_sum - (UROW_W+1)'(SCALED_HEIGHT);
        urow = urow_sum[UROW_W-1:0];

        ladv_sum = {1'b0, lower_off_reg} + {1'b0, lower_speed_reg};
        if (ladv_sum >= (LROW_W+1)'(TEX_HEIGHT))
            ladv_sum = ladv_sum - (LROW_W+1)'(TEX_HEIGHT);

        uadv_sum = {1'b0, upper_off_reg} + {1'b0, upper_speed_reg};
        if (uadv_sum >= (UROW_W+1)'(SCALED_HEIGHT))
            uadv_sum = uadv_sum - (UROW_W+1)'(SCALED_HEIGHT);
    end

    always_comb
    begin
        cmd_valid        = 1'b0;
        cmd.kind         = K_COMPUTE;
        cmd.mask_addr    = {lrow, col};
        cmd.scaled_addr  = {urow, col};
        cmd.value        = value;
        cmd.row          = row[LROW_W-1:0];
        cmd.col          = col;
        lower_off_next   = lower_off_reg;
        upper_off_next   = upper_off_reg;
        unique case (opcode_t'(opcode))
            OP_LOAD_MASK:
            begin
                cmd.kind      = K_LOAD_MASK;
                cmd.mask_addr = {row[LROW_W-1:0], col};
                cmd_valid     = accept && row_ok_mask && col_ok;
            end
            OP_LOAD_SCALED:
            begin
                cmd.kind        = K_LOAD_SCALED;
                cmd.scaled_addr = {row[UROW_W-1:0], col};
                cmd_valid       = accept && row_ok_scaled && col_ok;
            end
            OP_COMPUTE:
            begin
                cmd_valid = accept && row_ok_mask && col_ok;
            end
            OP_ADVANCE:
            begin
                if (accept)
                begin
                    lower_off_next = ladv_sum[LROW_W-1:0];
                    upper_off_next = uadv_sum[UROW_W-1:0];
                end
            end
        endcase
    end

    always_comb
    begin
        lower_speed_next = lower_speed_reg;
        upper_speed_next = upper_speed_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_LOWER_SPEED)
                lower_speed_next = cfg_data[LROW_W-1:0];
            else if (cfg_index == REG_UPPER_SPEED)
                upper_speed_next = cfg_data[UROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_speed_reg <= LOWER_SPEED_RESET;
            upper_speed_reg <= UPPER_SPEED_RESET;
            lower_off_reg   <= '0;
            upper_off_reg   <= UPPER_OFFSET_RESET;
        end
        else
        begin
            lower_speed_reg <= lower_speed_next;
            upper_speed_reg <= upper_speed_next;
            lower_off_reg   <= lower_off_next;
            upper_off_reg   <= upper_off_next;
        end
    end

    a_lower_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LROW_W+1)'(lower_off_reg) < (LROW_W+1)'(TEX_HEIGHT))
        else $error("lower offset out of range");

    a_upper_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        (UROW_W+1)'(upper_off_reg) < (UROW_W+1)'(SCALED_HEIGHT))
        else $error("upper offset out of range");

endmodule

// ----- hw/rtl/sftb_queue.sv -----
// ---------------------------------------------------------------------------
// sftb_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
module sftb_queue
    import sftb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = count_reg == Q_CNT_W'(Q_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count overflow");

endmodule

// ----- hw/rtl/sftb_back.sv -----
// ---------------------------------------------------------------------------
// sftb_back
// Executes queued commands: mask stores, registered mask reads, the
// three-stage blend pipeline and the result queue.
// ---------------------------------------------------------------------------
module sftb_back
    import sftb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cmd_t              q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [PIX_W-1:0]  pixel,
    output logic [LROW_W-1:0] out_row,
    output logic [COL_W-1:0]  out_col
);

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [LROW_W-1:0] row;
        logic [COL_W-1:0]  col;
    } res_t;

    logic [PIX_W-1:0] mask_mem   [TEX_HEIGHT*TEX_WIDTH];
    logic [PIX_W-1:0] scaled_mem [SCALED_HEIGHT*TEX_WIDTH];

    // stage 1: mask reads landed
    logic              st1_v_reg;
    logic [PIX_W-1:0]  m_rd_reg, s_rd_reg, st1_val_reg;
    logic [LROW_W-1:0] st1_row_reg;
    logic [COL_W-1:0]  st1_col_reg;
    // stage 2: both screens done
    logic              st2_v_reg;
    logic [PIX_W-1:0]  scr_lo_reg, scr_up2_reg, st2_val_reg;
    logic [LROW_W-1:0] st2_row_reg;
    logic [COL_W-1:0]  st2_col_reg;
    // stage 3: lower multiply done
    logic              st3_v_reg;
    logic [PIX_W-1:0]  low_reg, scr_up3_reg;
    logic [LROW_W-1:0] st3_row_reg;
    logic [COL_W-1:0]  st3_col_reg;

    res_t                 out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_reg, out_wr_next;
    logic [OUT_PTR_W-1:0] out_rd_reg, out_rd_next;
    logic [OUT_CNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic [OUT_CNT_W:0]   reserved;
    logic [2*PIX_W-1:0]   low_prod;
    logic [2*PIX_W-1:0]   px_prod;
    logic                 out_pop;
    res_t                 res_in;

    // hold off the queue unless every compute in flight has a result slot
    assign reserved = (OUT_CNT_W+1)'(out_cnt_reg) + (OUT_CNT_W+1)'(st1_v_reg)
                    + (OUT_CNT_W+1)'(st2_v_reg) + (OUT_CNT_W+1)'(st3_v_reg);
    assign q_pop    = !q_empty && (reserved < (OUT_CNT_W+1)'(OUT_DEPTH));

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.kind == K_LOAD_MASK)
            mask_mem[q_data.mask_addr] <= q_data.value;
        if (q_pop && q_data.kind == K_LOAD_SCALED)
            scaled_mem[q_data.scaled_addr] <= q_data.value;
        m_rd_reg <= mask_mem[q_data.mask_addr];
        s_rd_reg <= scaled_mem[q_data.scaled_addr];
    end

    assign low_prod = (2*PIX_W)'(scr_lo_reg) * (2*PIX_W)'(st2_val_reg);
    assign px_prod  = (2*PIX_W)'(low_reg) * (2*PIX_W)'(scr_up3_reg);

    always_ff @(posedge clk)
    begin
        st1_val_reg <= q_data.value;
        st1_row_reg <= q_data.row;
        st1_col_reg <= q_data.col;

        scr_lo_reg  <= screen_blend(st1_val_reg, m_rd_reg);
        scr_up2_reg <= screen_blend(st1_val_reg, s_rd_reg);
        st2_val_reg <= st1_val_reg;
        st2_row_reg <= st1_row_reg;
        st2_col_reg <= st1_col_reg;

        low_reg     <= low_prod[2*PIX_W-1:PIX_W];
        scr_up3_reg <= scr_up2_reg;
        st3_row_reg <= st2_row_reg;
        st3_col_reg <= st2_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
        end
        else
        begin
            st1_v_reg <= q_pop && q_data.kind == K_COMPUTE;
            st2_v_reg <= st1_v_reg;
            st3_v_reg <= st2_v_reg;
        end
    end

    // result queue
    assign empty   = out_cnt_reg == '0;
    assign out_pop = pop && !empty;
    assign pixel   = out_mem_reg[out_rd_reg].pixel;
    assign out_row = out_mem_reg[out_rd_reg].row;
    assign out_col = out_mem_reg[out_rd_reg].col;

    always_comb
    begin
        res_in.pixel = px_prod[2*PIX_W-1:PIX_W];
        res_in.row   = st3_row_reg;
        res_in.col   = st3_col_reg;
        out_wr_next  = out_wr_reg;
        out_rd_next  = out_rd_reg;
        out_cnt_next = out_cnt_reg;
        if (st3_v_reg)
            out_wr_next = out_wr_reg + 1'b1;
        if (out_pop)
            out_rd_next = out_rd_reg + 1'b1;
        if (st3_v_reg && !out_pop)
            out_cnt_next = out_cnt_reg + 1'b1;
        else if (out_pop && !st3_v_reg)
            out_cnt_next = out_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg  <= '0;
            out_rd_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            out_wr_reg  <= out_wr_next;
            out_rd_reg  <= out_rd_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st3_v_reg)
            out_mem_reg[out_wr_reg] <= res_in;
    end

    a_slots_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        reserved <= (OUT_CNT_W+1)'(OUT_DEPTH))
        else $error("result queue overcommitted");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (st3_v_reg && out_cnt_reg == OUT_CNT_W'(OUT_DEPTH)) |-> out_pop)
        else $error("result written into full queue");

endmodule

// ----- hw/rtl/scrolling_flame_texture_blend_core.sv -----
// ---------------------------------------------------------------------------
// scrolling_flame_texture_blend_core
// Flame texture generator: screen and multiply blend of a base pixel with
// two scrolling mask layers.
// ---------------------------------------------------------------------------
// Path: a compute result reaches the result ports through the command queue,
//   the registered mask read, the screen and lower multiply stages and the result queue.
// Throughput: one input beat per cycle while full is low; the 8-entry result queue holds the
//   pipeline off only when results are not popped.
// Reset: offsets 0 and 48, speeds 2 and 4, queues empty; mask stores are
//   not cleared and hold no data until loaded.
module scrolling_flame_texture_blend_core
    import sftb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            opcode,
    input  logic [ROW_W-1:0]      row,
    input  logic [COL_W-1:0]      col,
    input  logic [PIX_W-1:0]      value,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      pixel,
    output logic [LROW_W-1:0]     out_row,
    output logic [COL_W-1:0]      out_col,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic cmd_valid;
    cmd_t cmd;
    logic q_empty;
    logic q_pop;
    cmd_t q_data;

    sftb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    sftb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    sftb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .pixel   (pixel),
        .out_row (out_row),
        .out_col (out_col)
    );

endmodule
